### hw/rtl/tmce_pkg.sv
//------------------------------------------------------------------------------
// tmce_pkg
// Shared types, codes and constants of the text mode console engine.
//------------------------------------------------------------------------------
`default_nettype none

package tmce_pkg;

  localparam int MAX_COLUMNS_DEF = 80;
  localparam int MAX_ROWS_DEF    = 25;
  localparam int TAB_SHIFT       = 3;
  localparam int TAB_WIDTH       = 1 << TAB_SHIFT;

  localparam int COLS_W = 7;
  localparam int ROWS_W = 5;
  localparam int CW     = 11;
  localparam int CNT_W  = 7;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W   = 48;
  localparam int OUT_W  = 32;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [15:0] ATTR_MASK  = 16'hFF00;
  localparam logic [15:0] CHAR_MASK  = 16'h00FF;
  localparam logic [15:0] FG_MASK    = 16'hF000;
  localparam logic [15:0] BG_MASK    = 16'h0F00;
  localparam logic [15:0] SPACE_CHAR = 16'h0020;

  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LOW = 8'h20;
  localparam logic [7:0] CH_TOP = 8'h80;

  localparam logic [3:0] MODE_RESET  = 4'd0;
  localparam logic [3:0] MODE_PUTC   = 4'd1;
  localparam logic [3:0] MODE_CLEAR  = 4'd2;
  localparam logic [3:0] MODE_HILITE = 4'd3;
  localparam logic [3:0] MODE_MOVE   = 4'd4;
  localparam logic [3:0] MODE_SCRUP  = 4'd5;
  localparam logic [3:0] MODE_SCRDN  = 4'd6;
  localparam logic [3:0] MODE_SHOW   = 4'd7;
  localparam logic [3:0] MODE_READ   = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 3'd5;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_RD, ST_WR, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    WK_FILL, WK_SWAP, WK_PUTC, WK_SPACE, WK_READ, WK_COPY_UP, WK_COPY_DN
  } walk_t;

  typedef struct packed {
    walk_t            op;
    logic [CW-1:0]    row;
    logic [CW-1:0]    col;
    logic [CNT_W-1:0] rcnt;
    logic [CNT_W-1:0] ccnt;
  } phase_t;

endpackage

`default_nettype wire

### hw/rtl/text_mode_console_engine_top.sv
//------------------------------------------------------------------------------
// text_mode_console_engine_top
// Text cell buffer with cursor, driven by one command word per item.
//------------------------------------------------------------------------------
// After reset the block sweeps all MAX_COLUMNS*MAX_ROWS cells of the memory to
// blank, with in_tready low. Every command walks cells through the single
// memory, reading each cell and then writing it back: a printable character
// walks one cell, a rectangle w*h cells, a scroll width*height cells, a line
// feed on the last row cols*rows cells more. Move, show cursor and unused
// codes walk no cells. One result word is returned per command.
`default_nettype none

module text_mode_console_engine_top #(
  parameter int MAX_COLUMNS = tmce_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = tmce_pkg::MAX_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // mode[3:0], char_byte[11:4], pos_x[19:12], pos_y[27:20],
  // rect_width[34:28], rect_height[41:35], cursor_on[42], zero fill
  input  wire logic [tmce_pkg::IN_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // cursor_address[15:0], read_data[31:16]
  output logic [tmce_pkg::OUT_W-1:0]          out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [tmce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tmce_pkg::COLS_W-1:0]    cfg_wdata
);

  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = tmce_pkg::CW;
  localparam int CNT_W  = tmce_pkg::CNT_W;
  localparam int COLS_W = tmce_pkg::COLS_W;
  localparam int ROWS_W = tmce_pkg::ROWS_W;
  localparam int PW     = ROWS_W + COLS_W + 1;

  logic [15:0] mem [DEPTH];
  logic [15:0] mem_rdata_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic [COLS_W-1:0] cols_cfg_r, left_r, width_r;
  logic [ROWS_W-1:0] rows_cfg_r, top_r, height_r;
  logic [COLS_W-1:0] ncols;
  logic [ROWS_W-1:0] nrows;

  tmce_pkg::state_t  state_r, state_nxt;
  tmce_pkg::phase_t  ph_r, ph_nxt, ph2_r, ph2_nxt;
  logic              ph2_vld_r, ph2_vld_nxt;
  logic [CNT_W-1:0]  rc_r, rc_nxt, cc_r, cc_nxt;
  logic [CW-1:0]     row_r, row_nxt, col_r, col_nxt;
  logic              src_ok_r, src_ok_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [15:0]       rd_r, rd_nxt;
  logic [15:0]       ccol_r, ccol_nxt, crow_r, crow_nxt;
  logic              shown_r, shown_nxt;
  logic [ADDR_W-1:0] init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic [3:0]  f_mode;
  logic [7:0]  f_ch, f_x, f_y;
  logic [6:0]  f_w, f_h;
  logic        f_on;

  logic [15:0] pc_col, pc_row;
  logic        pc_scroll, pc_print;
  tmce_pkg::phase_t p1, p2;
  logic        p2_vld;

  logic [CW-1:0] src_row;
  logic          src_ok, dst_ok;
  logic [15:0]   v, cur_y, cur_x, cur_addr;

  assign f_mode = in_tdata[3:0];
  assign f_ch   = in_tdata[11:4];
  assign f_x    = in_tdata[19:12];
  assign f_y    = in_tdata[27:20];
  assign f_w    = in_tdata[34:28];
  assign f_h    = in_tdata[41:35];
  assign f_on   = in_tdata[42];

  function automatic logic on_scr(input logic [CW-1:0] r, input logic [CW-1:0] c,
                                  input logic [ROWS_W-1:0] nr,
                                  input logic [COLS_W-1:0] nc);
    on_scr = !r[CW-1] && (r[CW-2:0] < (CW-1)'(nr)) &&
             !c[CW-1] && (c[CW-2:0] < (CW-1)'(nc));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                  input logic [CW-1:0] c,
                                                  input logic [COLS_W-1:0] nc);
    logic [PW-1:0] p;
    p = ({{(COLS_W+1){1'b0}}, r[ROWS_W-1:0]} * {{(ROWS_W+1){1'b0}}, nc}) +
        {{(ROWS_W+1){1'b0}}, c[COLS_W-1:0]};
    cell_addr = ADDR_W'(p);
  endfunction

  always_comb begin
    if (cols_cfg_r == '0)                  ncols = COLS_W'(1);
    else if (int'(cols_cfg_r) > MAX_COLUMNS) ncols = COLS_W'(MAX_COLUMNS);
    else                                   ncols = cols_cfg_r;
    if (rows_cfg_r == '0)                  nrows = ROWS_W'(1);
    else if (int'(rows_cfg_r) > MAX_ROWS)  nrows = ROWS_W'(MAX_ROWS);
    else                                   nrows = rows_cfg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= COLS_W'(80);
      rows_cfg_r <= ROWS_W'(25);
      left_r     <= '0;
      top_r      <= '0;
      width_r    <= COLS_W'(80);
      height_r   <= ROWS_W'(25);
    end else if (cfg_we) begin
      case (cfg_index)
        tmce_pkg::CFG_COLS:   cols_cfg_r <= cfg_wdata;
        tmce_pkg::CFG_ROWS:   rows_cfg_r <= cfg_wdata[ROWS_W-1:0];
        tmce_pkg::CFG_LEFT:   left_r     <= cfg_wdata;
        tmce_pkg::CFG_TOP:    top_r      <= cfg_wdata[ROWS_W-1:0];
        tmce_pkg::CFG_WIDTH:  width_r    <= cfg_wdata;
        tmce_pkg::CFG_HEIGHT: height_r   <= cfg_wdata[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_col    = ccol_r;
    pc_row    = crow_r;
    pc_scroll = 1'b0;
    pc_print  = (f_ch >= tmce_pkg::CH_LOW) && (f_ch < tmce_pkg::CH_TOP);
    case (f_ch)
      tmce_pkg::CH_BS: begin
        if (pc_col != '0) begin
          pc_col = pc_col - 16'd1;
        end else if (pc_row != '0) begin
          pc_col = {9'b0, ncols} - 16'd1;
          pc_row = pc_row - 16'd1;
        end
      end
      tmce_pkg::CH_CR: pc_col = '0;
      tmce_pkg::CH_LF: begin
        pc_col = '0;
        pc_row = pc_row + 16'd1;
      end
      tmce_pkg::CH_TAB:
        pc_col = pc_col + (16'(tmce_pkg::TAB_WIDTH) -
                           (pc_col & 16'(tmce_pkg::TAB_WIDTH - 1)));
      default: if (pc_print) pc_col = pc_col + 16'd1;
    endcase
    if (pc_col >= {9'b0, ncols}) begin
      pc_col = '0;
      pc_row = pc_row + 16'd1;
    end
    if (pc_row >= {11'b0, nrows}) begin
      pc_row    = {11'b0, nrows} - 16'd1;
      pc_scroll = 1'b1;
    end
  end

  always_comb begin
    p1     = '{op: tmce_pkg::WK_FILL, row: '0, col: '0, rcnt: '0, ccnt: '0};
    p2     = p1;
    p2_vld = 1'b0;
    case (f_mode)
      tmce_pkg::MODE_RESET: begin
        p1.rcnt = CNT_W'(nrows);
        p1.ccnt = CNT_W'(ncols);
      end
      tmce_pkg::MODE_PUTC: begin
        p1.op  = tmce_pkg::WK_PUTC;
        p1.row = CW'(crow_r[ROWS_W-1:0]);
        p1.col = CW'(ccol_r[COLS_W-1:0]);
        if (pc_print && (crow_r < {11'b0, nrows}) && (ccol_r < {9'b0, ncols})) begin
          p1.rcnt = CNT_W'(1);
          p1.ccnt = CNT_W'(1);
        end
        p2.op   = tmce_pkg::WK_COPY_DN;
        p2.rcnt = CNT_W'(nrows);
        p2.ccnt = CNT_W'(ncols);
        p2_vld  = pc_scroll;
      end
      tmce_pkg::MODE_CLEAR, tmce_pkg::MODE_HILITE, tmce_pkg::MODE_READ: begin
        p1.op   = (f_mode == tmce_pkg::MODE_CLEAR)  ? tmce_pkg::WK_FILL :
                  (f_mode == tmce_pkg::MODE_HILITE) ? tmce_pkg::WK_SWAP : tmce_pkg::WK_READ;
        p1.row  = CW'(top_r) + {{(CW-8){f_y[7]}}, f_y};
        p1.col  = CW'(left_r) + {{(CW-8){f_x[7]}}, f_x};
        p1.rcnt = (f_mode == tmce_pkg::MODE_READ) ? CNT_W'(1) : f_h;
        p1.ccnt = (f_mode == tmce_pkg::MODE_READ) ? CNT_W'(1) : f_w;
      end
      tmce_pkg::MODE_SCRUP, tmce_pkg::MODE_SCRDN: begin
        p1.op   = (f_mode == tmce_pkg::MODE_SCRUP) ? tmce_pkg::WK_COPY_UP
                                                   : tmce_pkg::WK_COPY_DN;
        p1.row  = (f_mode == tmce_pkg::MODE_SCRUP) ?
                  CW'(top_r) + CW'(height_r) - CW'(1) : CW'(top_r);
        p1.col  = CW'(left_r);
        p1.rcnt = (height_r == '0) ? '0 : CNT_W'(height_r) - CNT_W'(1);
        p1.ccnt = width_r;
        p2.op   = tmce_pkg::WK_SPACE;
        p2.row  = (f_mode == tmce_pkg::MODE_SCRUP) ?
                  CW'(top_r) : CW'(top_r) + CW'(height_r) - CW'(1);
        p2.col  = CW'(left_r);
        p2.rcnt = CNT_W'(1);
        p2.ccnt = width_r;
        p2_vld  = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    case (ph_r.op)
      tmce_pkg::WK_COPY_UP: src_row = row_r - CW'(1);
      tmce_pkg::WK_COPY_DN: src_row = row_r + CW'(1);
      default:              src_row = row_r;
    endcase
    src_ok = on_scr(src_row, col_r, nrows, ncols);
    dst_ok = on_scr(row_r, col_r, nrows, ncols);
    v      = mem_rdata_r;
    cur_x  = shown_r ? ccol_r : '0;
    cur_y  = shown_r ? crow_r : {11'b0, nrows} + 16'd1;
    cur_addr = 16'(cur_y * {9'b0, ncols}) + cur_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tmce_pkg::ST_INIT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    ph2_nxt       = ph2_r;
    ph2_vld_nxt   = ph2_vld_r;
    rc_nxt        = rc_r;
    cc_nxt        = cc_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    src_ok_nxt    = src_ok_r;
    ch_nxt        = ch_r;
    rd_nxt        = rd_r;
    ccol_nxt      = ccol_r;
    crow_nxt      = crow_r;
    shown_nxt     = shown_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = cell_addr(row_r, col_r, ncols);
    mem_raddr     = cell_addr(src_row, col_r, ncols);
    mem_wdata     = tmce_pkg::BLANK_CELL;
    case (state_r)
      tmce_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_r;
        init_nxt  = init_r + ADDR_W'(1);
        if (int'(init_r) == DEPTH - 1) state_nxt = tmce_pkg::ST_IDLE;
      end
      tmce_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ph_nxt      = p1;
          ph2_nxt     = p2;
          ph2_vld_nxt = p2_vld;
          rc_nxt      = '0;
          cc_nxt      = '0;
          row_nxt     = p1.row;
          col_nxt     = p1.col;
          ch_nxt      = f_ch;
          rd_nxt      = '0;
          case (f_mode)
            tmce_pkg::MODE_RESET: begin
              ccol_nxt  = '0;
              crow_nxt  = '0;
              shown_nxt = 1'b1;
            end
            tmce_pkg::MODE_PUTC: begin
              ccol_nxt = pc_col;
              crow_nxt = pc_row;
            end
            tmce_pkg::MODE_MOVE: begin
              ccol_nxt = f_x[7] ? {9'b0, left_r} + {9'b0, width_r} + {{8{f_x[7]}}, f_x}
                                : {9'b0, left_r} + {{8{f_x[7]}}, f_x};
              crow_nxt = f_y[7] ? {11'b0, top_r} + {11'b0, height_r} + {{8{f_y[7]}}, f_y}
                                : {11'b0, top_r} + {{8{f_y[7]}}, f_y};
            end
            tmce_pkg::MODE_SHOW: shown_nxt = f_on;
            default: ;
          endcase
          state_nxt = tmce_pkg::ST_RD;
        end
      end
      tmce_pkg::ST_RD: begin
        if (ph_r.rcnt == '0 || ph_r.ccnt == '0) begin
          if (ph2_vld_r) begin
            ph_nxt      = ph2_r;
            ph2_vld_nxt = 1'b0;
            rc_nxt      = '0;
            cc_nxt      = '0;
            row_nxt     = ph2_r.row;
            col_nxt     = ph2_r.col;
          end else begin
            state_nxt = tmce_pkg::ST_DONE;
          end
        end else begin
          mem_re     = src_ok;
          src_ok_nxt = src_ok;
          state_nxt  = tmce_pkg::ST_WR;
        end
      end
      tmce_pkg::ST_WR: begin
        mem_we = dst_ok && (ph_r.op != tmce_pkg::WK_READ);
        case (ph_r.op)
          tmce_pkg::WK_SWAP:
            mem_wdata = (v & tmce_pkg::CHAR_MASK) | ((v << 4) & tmce_pkg::FG_MASK) |
                        ((v >> 4) & tmce_pkg::BG_MASK);
          tmce_pkg::WK_PUTC:  mem_wdata = (v & tmce_pkg::ATTR_MASK) | {8'b0, ch_r};
          tmce_pkg::WK_SPACE: mem_wdata = (v & tmce_pkg::ATTR_MASK) | tmce_pkg::SPACE_CHAR;
          tmce_pkg::WK_COPY_UP, tmce_pkg::WK_COPY_DN:
            mem_wdata = src_ok_r ? v : tmce_pkg::BLANK_CELL;
          tmce_pkg::WK_READ: rd_nxt = src_ok_r ? v : '0;
          default: mem_wdata = tmce_pkg::BLANK_CELL;
        endcase
        state_nxt = tmce_pkg::ST_RD;
        if (cc_r == ph_r.ccnt - CNT_W'(1)) begin
          cc_nxt  = '0;
          col_nxt = ph_r.col;
          if (rc_r == ph_r.rcnt - CNT_W'(1)) begin
            ph_nxt.rcnt = '0;
          end else begin
            rc_nxt  = rc_r + CNT_W'(1);
            row_nxt = (ph_r.op == tmce_pkg::WK_COPY_UP) ? row_r - CW'(1) : row_r + CW'(1);
          end
        end else begin
          cc_nxt  = cc_r + CNT_W'(1);
          col_nxt = col_r + CW'(1);
        end
      end
      tmce_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {rd_r, cur_addr};
          state_nxt     = tmce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tmce_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph2_vld_r   <= 1'b0;
      ccol_r      <= '0;
      crow_r      <= '0;
      shown_r     <= 1'b1;
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ph2_vld_r   <= ph2_vld_nxt;
      ccol_r      <= ccol_nxt;
      crow_r      <= crow_nxt;
      shown_r     <= shown_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph_r       <= ph_nxt;
    ph2_r      <= ph2_nxt;
    rc_r       <= rc_nxt;
    cc_r       <= cc_nxt;
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    src_ok_r   <= src_ok_nxt;
    ch_r       <= ch_nxt;
    rd_r       <= rd_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (int'(mem_waddr) < DEPTH))
    else $error("cell write beyond buffer");

  a_init_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmce_pkg::ST_INIT) |-> !in_tready)
    else $error("command taken during clearing pass");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == tmce_pkg::ST_RD))
    else $error("accepted command did not start a walk");

  a_read_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tmce_pkg::ST_WR && ph_r.op == tmce_pkg::WK_READ) |-> !mem_we)
    else $error("read cell wrote the buffer");

endmodule

`default_nettype wire
